/* hw/rtl/spnv_pkg.sv */
// ----------------------------------------------------------------------------
// spnv_pkg
// Shared constants for the segment/plane nearest-vertex pipeline.
// ----------------------------------------------------------------------------
package spnv_pkg;

  // default coordinate width (signed Q12.4)
  localparam int unsigned CoordWidthDef = 16;

  // vertex index codes
  localparam logic [1:0] VtxZero = 2'd0;
  localparam logic [1:0] VtxOne  = 2'd1;
  localparam logic [1:0] VtxTwo  = 2'd2;

endpackage

/* hw/rtl/segment_plane_nearest_vertex.sv */
// ----------------------------------------------------------------------------
// segment_plane_nearest_vertex
// Line/plane intersection point and nearest triangle vertex, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one item per clock while the skid entry is empty and gives one
// result per clock while the receiver is ready. The restoring divider takes
// one quotient bit per stage over COORD_WIDTH + 2 stages.
// An output register plus one skid entry let the pipeline keep taking items
// while a finished result waits; a transfer on the input side stops only
// once the skid entry is full.
module segment_plane_nearest_vertex #(
  parameter int unsigned COORD_WIDTH = spnv_pkg::CoordWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [3*COORD_WIDTH-1:0]   line_start_i,
  input  logic [3*COORD_WIDTH-1:0]   line_end_i,
  input  logic [3*COORD_WIDTH-1:0]   vertex_zero_i,
  input  logic [3*COORD_WIDTH-1:0]   vertex_one_i,
  input  logic [3*COORD_WIDTH-1:0]   vertex_two_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 nearest_index_o,
  output logic [3*COORD_WIDTH-1:0]   hit_point_o,
  output logic                       parallel_flag_o
);
  import spnv_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned E  = W + 1;          // coordinate differences
  localparam int unsigned NW = 2 * W + 3;      // normal components
  localparam int unsigned TW = E + NW;         // dot product terms
  localparam int unsigned AW = 3 * W + 6;      // dot product sums
  localparam int unsigned LO = (AW + 1) / 2;
  localparam int unsigned HI = AW - LO;
  localparam int unsigned PW = AW + E;         // |num| * |d|
  localparam int unsigned QW = W + 2;          // quotient bits
  localparam int unsigned RW = AW + QW + 2;    // dividend / remainder
  localparam int unsigned DW = 2 * W + 4;      // squared distance

  localparam logic [QW-1:0] OffLim = QW'(1) << (W + 1);
  localparam logic signed [W+2:0] CMax = (W + 3)'((1 << (W - 1)) - 1);
  localparam logic signed [W+2:0] CMin = -CMax - (W + 3)'(1);

  typedef struct packed {
    logic [2:0][W-1:0] s;
    logic [2:0][W-1:0] a;
    logic [2:0][W-1:0] b;
    logic [2:0][W-1:0] c;
  } pts_t;

  typedef struct packed {
    pts_t      pts;
    logic [2:0] neg;
    logic [2:0] ovf;
    logic      par;
    logic [AW:0] dvs;
  } carry_t;

  logic en;
  logic sk_v_q;
  assign en         = !sk_v_q;
  assign in_ready_o = en;

  // ---------------- stage 1: unpack and differences ----------------
  logic s1_v_q;
  pts_t s1_pts_d, s1_pts_q;
  logic signed [E-1:0] s1_e1_d [3], s1_e2_d [3], s1_sa_d [3], s1_se_d [3], s1_dd_d [3];
  logic signed [E-1:0] s1_e1_q [3], s1_e2_q [3], s1_sa_q [3], s1_se_q [3], s1_dd_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_pts_d.s[k] = line_start_i[k*W +: W];
      s1_pts_d.a[k] = vertex_zero_i[k*W +: W];
      s1_pts_d.b[k] = vertex_one_i[k*W +: W];
      s1_pts_d.c[k] = vertex_two_i[k*W +: W];
      s1_e1_d[k] = E'($signed(vertex_one_i[k*W +: W])) - E'($signed(vertex_zero_i[k*W +: W]));
      s1_e2_d[k] = E'($signed(vertex_two_i[k*W +: W])) - E'($signed(vertex_zero_i[k*W +: W]));
      s1_sa_d[k] = E'($signed(line_start_i[k*W +: W])) - E'($signed(vertex_zero_i[k*W +: W]));
      s1_se_d[k] = E'($signed(line_start_i[k*W +: W])) - E'($signed(line_end_i[k*W +: W]));
      s1_dd_d[k] = -s1_se_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pts_q <= s1_pts_d;
      s1_e1_q  <= s1_e1_d;
      s1_e2_q  <= s1_e2_d;
      s1_sa_q  <= s1_sa_d;
      s1_se_q  <= s1_se_d;
      s1_dd_q  <= s1_dd_d;
    end
  end

  // ---------------- stage 2: cross product partials ----------------
  logic s2_v_q;
  pts_t s2_pts_q;
  logic signed [2*E-1:0] s2_p_q [6];
  logic signed [E-1:0] s2_sa_q [3], s2_se_q [3], s2_dd_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_p_q[0] <= s1_e1_q[1] * s1_e2_q[2];
      s2_p_q[1] <= s1_e1_q[2] * s1_e2_q[1];
      s2_p_q[2] <= s1_e1_q[2] * s1_e2_q[0];
      s2_p_q[3] <= s1_e1_q[0] * s1_e2_q[2];
      s2_p_q[4] <= s1_e1_q[0] * s1_e2_q[1];
      s2_p_q[5] <= s1_e1_q[1] * s1_e2_q[0];
      s2_pts_q  <= s1_pts_q;
      s2_sa_q   <= s1_sa_q;
      s2_se_q   <= s1_se_q;
      s2_dd_q   <= s1_dd_q;
    end
  end

  // ---------------- stage 3: normal ----------------
  logic s3_v_q;
  pts_t s3_pts_q;
  logic signed [NW-1:0] s3_n_q [3];
  logic signed [E-1:0] s3_sa_q [3], s3_se_q [3], s3_dd_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s3_n_q[k] <= NW'(s2_p_q[2*k]) - NW'(s2_p_q[2*k+1]);
      end
      s3_pts_q <= s2_pts_q;
      s3_sa_q  <= s2_sa_q;
      s3_se_q  <= s2_se_q;
      s3_dd_q  <= s2_dd_q;
    end
  end

  // ---------------- stage 4: dot product terms ----------------
  logic s4_v_q;
  pts_t s4_pts_q;
  logic signed [TW-1:0] s4_tn_q [3], s4_td_q [3];
  logic signed [E-1:0] s4_dd_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s4_tn_q[k] <= TW'(s3_sa_q[k]) * TW'(s3_n_q[k]);
        s4_td_q[k] <= TW'(s3_se_q[k]) * TW'(s3_n_q[k]);
      end
      s4_pts_q <= s3_pts_q;
      s4_dd_q  <= s3_dd_q;
    end
  end

  // ---------------- stage 5: numerator and denominator ----------------
  logic s5_v_q;
  pts_t s5_pts_q;
  logic signed [AW-1:0] s5_num_q, s5_den_q;
  logic signed [E-1:0] s5_dd_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_num_q <= AW'(s4_tn_q[0]) + AW'(s4_tn_q[1]) + AW'(s4_tn_q[2]);
      s5_den_q <= AW'(s4_td_q[0]) + AW'(s4_td_q[1]) + AW'(s4_td_q[2]);
      s5_pts_q <= s4_pts_q;
      s5_dd_q  <= s4_dd_q;
    end
  end

  // ---------------- stage 6: magnitudes and signs ----------------
  logic s6_v_q;
  pts_t s6_pts_q;
  logic [AW-1:0] s6_an_q, s6_ad_q;
  logic [E-1:0]  s6_dm_q [3];
  logic [2:0]    s6_neg_q;
  logic          s6_par_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_an_q  <= s5_num_q[AW-1] ? AW'(-s5_num_q) : AW'(s5_num_q);
      s6_ad_q  <= s5_den_q[AW-1] ? AW'(-s5_den_q) : AW'(s5_den_q);
      s6_par_q <= (s5_den_q == '0);
      for (int k = 0; k < 3; k++) begin
        s6_dm_q[k]  <= s5_dd_q[k][E-1] ? E'(-s5_dd_q[k]) : E'(s5_dd_q[k]);
        s6_neg_q[k] <= s5_num_q[AW-1] ^ s5_den_q[AW-1] ^ s5_dd_q[k][E-1];
      end
      s6_pts_q <= s5_pts_q;
    end
  end

  // ---------------- stage 7: split products |num| * |d| ----------------
  logic s7_v_q;
  pts_t s7_pts_q;
  logic [LO+E-1:0] s7_plo_q [3];
  logic [HI+E-1:0] s7_phi_q [3];
  logic [AW-1:0]   s7_ad_q;
  logic [2:0]      s7_neg_q;
  logic            s7_par_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else if (en) begin
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s7_plo_q[k] <= (LO + E)'(s6_an_q[LO-1:0]) * (LO + E)'(s6_dm_q[k]);
        s7_phi_q[k] <= (HI + E)'(s6_an_q[AW-1:LO]) * (HI + E)'(s6_dm_q[k]);
      end
      s7_ad_q  <= s6_ad_q;
      s7_neg_q <= s6_neg_q;
      s7_par_q <= s6_par_q;
      s7_pts_q <= s6_pts_q;
    end
  end

  // ---------------- stage 8: rounded dividend and divisor ----------------
  logic s8_v_q;
  pts_t s8_pts_q;
  logic [RW-1:0] s8_n_q [3];
  logic [AW:0]   s8_dvs_q;
  logic [2:0]    s8_neg_q;
  logic          s8_par_q;
  logic [PW-1:0] s8_prod_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s8_prod_d[k] = (PW'(s7_phi_q[k]) << LO) + PW'(s7_plo_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else if (en) begin
      s8_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s8_n_q[k] <= (RW'(s8_prod_d[k]) << 1) + RW'(s7_ad_q);
      end
      s8_dvs_q <= {s7_ad_q, 1'b0};
      s8_neg_q <= s7_neg_q;
      s8_par_q <= s7_par_q;
      s8_pts_q <= s7_pts_q;
    end
  end

  // ---------------- divider: overflow check, then one bit per stage ----------------
  logic         dv_v_q   [QW+1];
  carry_t       dv_cy_q  [QW+1];
  logic [RW-1:0] dv_rem_q [QW+1][3];
  logic [QW-1:0] dv_quo_q [QW+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= s8_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_cy_q[0].pts <= s8_pts_q;
      dv_cy_q[0].neg <= s8_neg_q;
      dv_cy_q[0].par <= s8_par_q;
      dv_cy_q[0].dvs <= s8_dvs_q;
      for (int k = 0; k < 3; k++) begin
        dv_cy_q[0].ovf[k] <= (s8_n_q[k] >= (RW'(s8_dvs_q) << QW));
        dv_rem_q[0][k]    <= s8_n_q[k];
        dv_quo_q[0][k]    <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW-1:0] sub_d [3];
    logic [2:0]    bit_d;

    // trial subtract of the divisor shifted to this quotient bit
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        sub_d[k] = RW'(dv_cy_q[j].dvs) << (QW - 1 - j);
        bit_d[k] = (dv_rem_q[j][k] >= sub_d[k]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_cy_q[j+1] <= dv_cy_q[j];
        for (int k = 0; k < 3; k++) begin
          dv_rem_q[j+1][k] <= bit_d[k] ? dv_rem_q[j][k] - sub_d[k] : dv_rem_q[j][k];
          dv_quo_q[j+1][k] <= {dv_quo_q[j][k][QW-2:0], bit_d[k]};
        end
      end
    end
  end

  // ---------------- hit point: clamp offset, add, saturate; start point if parallel ----------------
  logic fn_v_q;
  pts_t fn_pts_q;
  logic [2:0][W-1:0] fn_p_q;
  logic              fn_par_q;
  logic [W-1:0]      fn_p_d [3];

  always_comb begin
    logic [QW-1:0]     qm;
    logic signed [W+2:0] sum;
    for (int k = 0; k < 3; k++) begin
      qm  = (dv_cy_q[QW].ovf[k] || (dv_quo_q[QW][k] > OffLim)) ? OffLim : dv_quo_q[QW][k];
      sum = (W + 3)'($signed(dv_cy_q[QW].pts.s[k]));
      sum = dv_cy_q[QW].neg[k] ? sum - $signed({1'b0, qm}) : sum + $signed({1'b0, qm});
      if (dv_cy_q[QW].par) begin
        fn_p_d[k] = dv_cy_q[QW].pts.s[k];
      end else if (sum > CMax) begin
        fn_p_d[k] = W'(CMax);
      end else if (sum < CMin) begin
        fn_p_d[k] = W'(CMin);
      end else begin
        fn_p_d[k] = W'(sum);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_v_q <= 1'b0;
    end else if (en) begin
      fn_v_q <= dv_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        fn_p_q[k] <= fn_p_d[k];
      end
      fn_par_q <= dv_cy_q[QW].par;
      fn_pts_q <= dv_cy_q[QW].pts;
    end
  end

  // ---------------- squared distance terms ----------------
  logic sq_v_q;
  logic [2*E-1:0]    sq_t_q [3][3];
  logic [2:0][W-1:0] sq_p_q;
  logic              sq_par_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
    end else if (en) begin
      sq_v_q <= fn_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [E-1:0] df;
    logic [W-1:0]        vc;
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int k = 0; k < 3; k++) begin
          vc = (v == 0) ? fn_pts_q.a[k] : (v == 1) ? fn_pts_q.b[k] : fn_pts_q.c[k];
          df = E'($signed(fn_p_q[k])) - E'($signed(vc));
          sq_t_q[v][k] <= (2 * E)'(df) * (2 * E)'(df);
        end
      end
      sq_p_q   <= fn_p_q;
      sq_par_q <= fn_par_q;
    end
  end

  // ---------------- distance sums and nearest pick ----------------
  logic [DW-1:0] dsq [3];
  logic [1:0]    idx_d;

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      dsq[v] = DW'(sq_t_q[v][0]) + DW'(sq_t_q[v][1]) + DW'(sq_t_q[v][2]);
    end
    if (dsq[0] > dsq[1]) begin
      if (dsq[0] > dsq[2]) begin
        idx_d = (dsq[2] > dsq[1]) ? VtxOne : VtxTwo;
      end else begin
        idx_d = VtxOne;
      end
    end else begin
      if (dsq[1] > dsq[2]) begin
        idx_d = (dsq[2] > dsq[0]) ? VtxZero : VtxTwo;
      end else begin
        idx_d = VtxZero;
      end
    end
  end

  // ---------------- output register and skid entry ----------------
  logic              out_v_q;
  logic [1:0]        out_idx_q, sk_idx_q;
  logic [3*W-1:0]    out_hit_q, sk_hit_q;
  logic              out_par_q, sk_par_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q <= sk_v_q | sq_v_q;
      sk_v_q  <= 1'b0;
    end else if (sq_v_q && en) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      if (sk_v_q) begin
        out_idx_q <= sk_idx_q;
        out_hit_q <= sk_hit_q;
        out_par_q <= sk_par_q;
      end else begin
        out_idx_q <= idx_d;
        out_hit_q <= sq_p_q;
        out_par_q <= sq_par_q;
      end
    end else if (en) begin
      sk_idx_q <= idx_d;
      sk_hit_q <= sq_p_q;
      sk_par_q <= sq_par_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign nearest_index_o = out_idx_q;
  assign hit_point_o     = out_hit_q;
  assign parallel_flag_o = out_par_q;

endmodule

/* test/segment_plane_nearest_vertex_test.sv */
// ----------------------------------------------------------------------------
// segment_plane_nearest_vertex_test
// Self-checking bench for the segment/plane nearest-vertex pipeline.
// ----------------------------------------------------------------------------
// A driver offers queued queries in bursts and a receiver stalls on its own
// pattern, with one long hold-off that backs the pipeline up. Each accepted
// query is run through an exact integer predictor, and each result transfer
// is checked field by field against the oldest prediction.
module segment_plane_nearest_vertex_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spnv_pkg::*;

  localparam int unsigned W = CoordWidthDef;
  localparam int unsigned PW = 3 * W;
  localparam int unsigned NumRandom = 1250;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [PW-1:0] start_pt;
    logic [PW-1:0] end_pt;
    logic [PW-1:0] v0;
    logic [PW-1:0] v1;
    logic [PW-1:0] v2;
  } query_t;

  typedef struct packed {
    logic [1:0]    index;
    logic [PW-1:0] point;
    logic          parallel;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PW-1:0] line_start = '0;
  logic [PW-1:0] line_end = '0;
  logic [PW-1:0] vtx_zero = '0;
  logic [PW-1:0] vtx_one = '0;
  logic [PW-1:0] vtx_two = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] nearest_index;
  logic [PW-1:0] hit_point;
  logic parallel_flag;

  query_t query_queue[$];
  hit_t   hit_expect_q[$];
  int unsigned mismatches = 0;
  int unsigned in_count = 0;

  segment_plane_nearest_vertex DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .line_start_i   (line_start),
    .line_end_i     (line_end),
    .vertex_zero_i  (vtx_zero),
    .vertex_one_i   (vtx_one),
    .vertex_two_i   (vtx_two),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .nearest_index_o(nearest_index),
    .hit_point_o    (hit_point),
    .parallel_flag_o(parallel_flag)
  );

  always #10 clk_i = ~clk_i;

  // exact intersection point and nearest vertex
  function automatic hit_t predict_hit(input query_t q);
    longint s[3], e[3], a[3], b[3], c[3], e1[3], e2[3], n[3], p[3], dsq[3];
    longint num, den, d, v, diff;
    logic [127:0] an, ad, dm, prod, quo;
    longint qm;
    bit neg;
    hit_t r;
    num = 0;
    den = 0;
    for (int k = 0; k < 3; k++) begin
      s[k] = longint'($signed(q.start_pt[k*W +: W]));
      e[k] = longint'($signed(q.end_pt[k*W +: W]));
      a[k] = longint'($signed(q.v0[k*W +: W]));
      b[k] = longint'($signed(q.v1[k*W +: W]));
      c[k] = longint'($signed(q.v2[k*W +: W]));
      e1[k] = b[k] - a[k];
      e2[k] = c[k] - a[k];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int k = 0; k < 3; k++) begin
      num += (s[k] - a[k]) * n[k];
      den += (s[k] - e[k]) * n[k];
    end
    r.parallel = (den == 0);
    r.point = '0;
    for (int k = 0; k < 3; k++) begin
      if (r.parallel) begin
        p[k] = s[k];
      end else begin
        d = e[k] - s[k];
        an = 128'(num < 0 ? -num : num);
        ad = 128'(den < 0 ? -den : den);
        dm = 128'(d < 0 ? -d : d);
        neg = ((num < 0) != (den < 0)) != (d < 0);
        prod = an * dm;
        // round half away from zero
        quo = ((prod << 1) + ad) / (ad << 1);
        qm = (quo > 128'(1 << (W + 1))) ? longint'(1 << (W + 1)) : longint'(quo);
        v = s[k] + (neg ? -qm : qm);
        if (v > (1 <<< (W - 1)) - 1) v = (1 <<< (W - 1)) - 1;
        if (v < -(1 <<< (W - 1))) v = -(1 <<< (W - 1));
        p[k] = v;
      end
      r.point[k*W +: W] = p[k][W-1:0];
    end
    for (int k = 0; k < 3; k++) begin
      dsq[k] = 0;
      for (int j = 0; j < 3; j++) begin
        diff = p[j] - ((k == 0) ? a[j] : (k == 1) ? b[j] : c[j]);
        dsq[k] += diff * diff;
      end
    end
    // ties: v0/v1 -> 0, v0/v2 -> 2, v1/v2 -> 2, all three -> 0
    if (dsq[0] > dsq[1]) begin
      if (dsq[0] > dsq[2]) r.index = (dsq[2] > dsq[1]) ? VtxOne : VtxTwo;
      else r.index = VtxOne;
    end else begin
      if (dsq[1] > dsq[2]) r.index = (dsq[2] > dsq[0]) ? VtxZero : VtxTwo;
      else r.index = VtxZero;
    end
    return r;
  endfunction

  function automatic logic [PW-1:0] pack3(input int x, input int y, input int z);
    logic [31:0] xs, ys, zs;
    xs = x;
    ys = y;
    zs = z;
    return {zs[W-1:0], ys[W-1:0], xs[W-1:0]};
  endfunction

  function automatic logic [PW-1:0] rand_wide();
    return PW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [PW-1:0] rand_near(input int span);
    return pack3($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                 $urandom_range(2 * span) - span);
  endfunction

  // sender: bursts with gaps, valid held until the transfer
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic nv;
    query_t qn;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      nv = 1'b0;
      if (in_valid && in_ready) begin
        hit_expect_q.push_back(predict_hit({line_start, line_end, vtx_zero, vtx_one,
                                            vtx_two}));
        void'(query_queue.pop_front());
        in_count++;
      end
      if (in_valid && !in_ready) begin
        nv = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (query_queue.size() > 0) begin
        qn = query_queue[0];
        {line_start, line_end, vtx_zero, vtx_one, vtx_two} <= qn;
        nv = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(40, 1);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end
      end
      in_valid <= nv;
    end
  end

  // receiver: stall pattern re-drawn at random, plus one long hold-off
  int unsigned stall_mode = 0;
  int unsigned mode_cycles = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && in_count >= 400) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      mode_cycles++;
      if (mode_cycles == 64) begin
        mode_cycles = 0;
        stall_mode = $urandom_range(3);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(1);
          2: out_ready <= ($urandom_range(3) == 0);
          default: out_ready <= ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    hit_t got, want;
    if (rst_ni && out_valid && out_ready) begin
      got = '{nearest_index, hit_point, parallel_flag};
      if (hit_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = hit_expect_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: index exp %0d got %0d, point exp %h got %h, par exp %b got %b",
                     want.index, got.index, want.point, got.point, want.parallel,
                     got.parallel);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("segment_plane_nearest_vertex test failed");
      $finish;
    end
  end

  initial begin
    logic [PW-1:0] mx, mn;
    int sel;
    mx = pack3(32767, 32767, 32767);
    mn = pack3(-32768, -32768, -32768);
    // directed: all zero, degenerate triangle, equal distances
    query_queue.push_back('{'0, '0, '0, '0, '0});
    query_queue.push_back('{mx, mn, mx, mn, mx});
    query_queue.push_back('{mn, mx, mn, mx, pack3(-32768, 32767, 0)});
    query_queue.push_back('{mx, mx, mx, mx, mx});
    query_queue.push_back('{mn, mx, pack3(0, 0, 0), pack3(32767, 0, 0),
                            pack3(0, -32768, 32767)});
    // line parallel to z=0 triangle
    query_queue.push_back('{pack3(5, 7, 32), pack3(-80, 90, 32), pack3(0, 0, 0),
                            pack3(64, 0, 0), pack3(0, 64, 0)});
    // start on plane
    query_queue.push_back('{pack3(10, 20, 0), pack3(30, 5, 16), pack3(0, 0, 0),
                            pack3(64, 0, 0), pack3(0, 64, 0)});
    // ordinary crossing, one per nearest vertex
    query_queue.push_back('{pack3(2, 2, -16), pack3(2, 2, 16), pack3(0, 0, 0),
                            pack3(64, 0, 0), pack3(0, 64, 0)});
    query_queue.push_back('{pack3(60, 3, -16), pack3(60, 3, 16), pack3(0, 0, 0),
                            pack3(64, 0, 0), pack3(0, 64, 0)});
    query_queue.push_back('{pack3(3, 60, -16), pack3(3, 60, 16), pack3(0, 0, 0),
                            pack3(64, 0, 0), pack3(0, 64, 0)});
    // ties: v0/v1 -> 0, v0/v2 -> 2, v1/v2 -> 2, all three -> 0
    query_queue.push_back('{pack3(32, -20, -16), pack3(32, -20, 16), pack3(0, 0, 0),
                            pack3(64, 0, 0), pack3(0, 64, 0)});
    query_queue.push_back('{pack3(-20, 32, -16), pack3(-20, 32, 16), pack3(0, 0, 0),
                            pack3(64, 0, 0), pack3(0, 64, 0)});
    query_queue.push_back('{pack3(40, 40, -16), pack3(40, 40, 16), pack3(0, 0, 0),
                            pack3(64, 0, 0), pack3(0, 64, 0)});
    query_queue.push_back('{pack3(32, 32, -16), pack3(32, 32, 16), pack3(0, 0, 0),
                            pack3(64, 0, 0), pack3(0, 64, 0)});
    // far intersection saturating high and low
    query_queue.push_back('{pack3(32000, -32000, 16), pack3(32767, -32768, 15),
                            pack3(0, 0, 0), pack3(64, 0, 0), pack3(0, 64, 0)});
    query_queue.push_back('{pack3(-32000, 32000, -16), pack3(-32768, 32767, -15),
                            pack3(0, 0, 0), pack3(64, 0, 0), pack3(0, 64, 0)});
    query_queue.push_back('{mx, mn, mn, mx, pack3(32767, -32768, 32767)});
    // random: full-range, small-span for ties, medium-span, and parallel lines
    for (int i = 0; i < NumRandom; i++) begin
      sel = $urandom_range(9);
      if (sel < 4) begin
        query_queue.push_back('{rand_wide(), rand_wide(), rand_wide(), rand_wide(),
                                rand_wide()});
      end else if (sel < 8) begin
        query_queue.push_back('{rand_near(8), rand_near(8), rand_near(8), rand_near(8),
                                rand_near(8)});
      end else if (sel == 8) begin
        query_queue.push_back('{rand_near(2000), rand_near(2000), rand_near(400),
                                rand_near(400), rand_near(400)});
      end else begin
        query_queue.push_back('{pack3($urandom_range(200) - 100, $urandom_range(200) - 100, 48),
                                pack3($urandom_range(200) - 100, $urandom_range(200) - 100, 48),
                                pack3(0, 0, 0), pack3($urandom_range(100) + 1, 0, 0),
                                pack3(0, $urandom_range(100) + 1, 0)});
      end
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (query_queue.size() > 0 || in_valid) @(posedge clk_i);
    while (hit_expect_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && hit_expect_q.size() == 0) begin
      $display("segment_plane_nearest_vertex test passed");
    end else begin
      $display("segment_plane_nearest_vertex test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/spnv_pkg.sv
hw/rtl/segment_plane_nearest_vertex.sv
test/segment_plane_nearest_vertex_test.sv
